// ===== hw/rtl/psts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-symbol tick statistics package
// Shared types and constants for the tick statistics block.
// ----------------------------------------------------------------------------
package psts_pkg;

    localparam int NUM_SYMBOLS = 256;
    localparam int IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0]  symbol_id;
        logic [31:0] price;
        logic [23:0] quantity;
        logic        side;
        logic [63:0] sent_time_ns;
        logic [63:0] arrival_time_ns;
    } tick_in_t;

    typedef struct packed {
        logic [7:0]  entry_symbol;
        logic [31:0] tick_count;
        logic [63:0] price_volume_sum;
        logic [47:0] volume_sum;
        logic [31:0] min_price;
        logic [31:0] max_price;
        logic [31:0] last_bid;
        logic [31:0] last_ask;
        logic [31:0] spread;
        logic [31:0] processed_count;
        logic [63:0] latency_sum;
    } tick_out_t;

    // Classified work handed from the front part to the back part.
    typedef struct packed {
        logic [7:0]       symbol_id;
        logic [IDX_W-1:0] idx;
        logic [31:0]      price;
        logic [23:0]      quantity;
        logic             side;
        logic             lat_valid;
        logic [63:0]      latency;
    } work_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_READ,
        ST_UPDATE,
        ST_WRITE
    } back_state_t;

endpackage

// ===== hw/rtl/psts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick front end
// Accepts ticks, maps the symbol to a table index and forms the latency.
// ----------------------------------------------------------------------------
module psts_front (
    input  logic               clk,
    input  logic               rst_n,
    input  psts_pkg::tick_in_t in_data,
    input  logic               in_valid,
    output logic               in_ready,
    output psts_pkg::work_t    wk_data,
    output logic               wk_valid,
    input  logic               wk_ready
);
    import psts_pkg::*;

    work_t wk_reg;
    logic  valid_reg;
    logic  [64:0] diff;

    assign in_ready = !valid_reg || wk_ready;
    assign wk_data  = wk_reg;
    assign wk_valid = valid_reg;
    assign diff = {1'b0, in_data.arrival_time_ns} - {1'b0, in_data.sent_time_ns};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            wk_reg.symbol_id <= in_data.symbol_id;
            wk_reg.idx       <= IDX_W'(32'(in_data.symbol_id) % NUM_SYMBOLS);
            wk_reg.price     <= in_data.price;
            wk_reg.quantity  <= in_data.quantity;
            wk_reg.side      <= in_data.side;
            wk_reg.lat_valid <= !diff[64];
            wk_reg.latency   <= diff[63:0];
        end
    end

endmodule

// ===== hw/rtl/psts_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Work queue
// Short queue that decouples the front end from the table update.
// ----------------------------------------------------------------------------
module psts_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  psts_pkg::work_t wr_data,
    input  logic            wr_valid,
    output logic            wr_ready,
    output psts_pkg::work_t rd_data,
    output logic            rd_valid,
    input  logic            rd_ready
);
    import psts_pkg::*;

    work_t slot_reg [QUEUE_DEPTH];
    logic  [0:0] wp_reg;
    logic  [0:0] rp_reg;
    logic  [1:0] cnt_reg;
    logic  push;
    logic  pop;

    assign wr_ready = cnt_reg != 2'(QUEUE_DEPTH);
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = slot_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not grow on push");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/psts_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table update engine
// Read-modify-write of one symbol entry per item, plus global totals.
// ----------------------------------------------------------------------------
module psts_back (
    input  logic                clk,
    input  logic                rst_n,
    input  psts_pkg::work_t     wk_data,
    input  logic                wk_valid,
    output logic                wk_ready,
    output psts_pkg::tick_out_t out_data,
    output logic                out_valid,
    input  logic                out_ready
);
    import psts_pkg::*;

    localparam int ENT_W = 32 + 64 + 48 + 32 + 32 + 32 + 32;

    typedef struct packed {
        logic [31:0] cnt;
        logic [63:0] pv;
        logic [47:0] vol;
        logic [31:0] mn;
        logic [31:0] mx;
        logic [31:0] bid;
        logic [31:0] ask;
    } entry_t;

    logic [ENT_W-1:0] mem [NUM_SYMBOLS];

    back_state_t state_reg, state_next;
    logic [IDX_W:0] clr_reg, clr_next;
    work_t     wk_reg;
    entry_t    rd_reg;
    entry_t    upd_reg, upd_next;
    logic [63:0] prod_reg;
    tick_out_t res_reg;
    logic      res_valid_reg, res_valid_next;
    logic [31:0] proc_reg, proc_next;
    logic [63:0] lat_reg, lat_next;
    logic      take, mem_we, load_res;
    logic [IDX_W-1:0] mem_addr;
    logic [ENT_W-1:0] mem_wdata;
    logic [64:0] pv_sum, lat_sum;
    logic [48:0] vol_sum;
    logic [31:0] spr;
    entry_t    clr_ent;
    logic      pend_reg;

    assign out_data  = res_reg;
    assign out_valid = res_valid_reg;
    assign take      = wk_valid && wk_ready;

    always_comb
    begin
        clr_ent = '0;
        clr_ent.mn = '1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (take)
        begin
            wk_reg <= wk_data;
        end
        rd_reg   <= entry_t'(mem[wk_reg.idx]);
        prod_reg <= 64'(wk_reg.price) * 64'(wk_reg.quantity);
        if (state_reg == ST_UPDATE)
        begin
            upd_reg <= upd_next;
        end
        if (load_res)
        begin
            res_reg.entry_symbol     <= wk_reg.symbol_id;
            res_reg.tick_count       <= upd_reg.cnt;
            res_reg.price_volume_sum <= upd_reg.pv;
            res_reg.volume_sum       <= upd_reg.vol;
            res_reg.min_price        <= upd_reg.mn;
            res_reg.max_price        <= upd_reg.mx;
            res_reg.last_bid         <= upd_reg.bid;
            res_reg.last_ask         <= upd_reg.ask;
            res_reg.spread           <= spr;
            res_reg.processed_count  <= proc_next;
            res_reg.latency_sum      <= lat_next;
        end
    end

    // Entry arithmetic, from the registered read data and product.
    always_comb
    begin
        pv_sum  = {1'b0, rd_reg.pv} + {1'b0, prod_reg};
        vol_sum = {1'b0, rd_reg.vol} + 49'(wk_reg.quantity);
        upd_next.cnt = (rd_reg.cnt == '1) ? rd_reg.cnt : rd_reg.cnt + 32'd1;
        upd_next.pv  = pv_sum[64] ? '1 : pv_sum[63:0];
        upd_next.vol = vol_sum[48] ? '1 : vol_sum[47:0];
        upd_next.mn  = (wk_reg.price < rd_reg.mn) ? wk_reg.price : rd_reg.mn;
        upd_next.mx  = (wk_reg.price > rd_reg.mx) ? wk_reg.price : rd_reg.mx;
        upd_next.bid = wk_reg.side ? rd_reg.bid : wk_reg.price;
        upd_next.ask = wk_reg.side ? wk_reg.price : rd_reg.ask;
    end

    always_comb
    begin
        if (upd_reg.bid != '0 && upd_reg.ask != '0)
        begin
            spr = (upd_reg.ask >= upd_reg.bid) ? upd_reg.ask - upd_reg.bid
                                               : upd_reg.bid - upd_reg.ask;
        end
        else
        begin
            spr = '0;
        end
        lat_sum   = {1'b0, lat_reg} + {1'b0, wk_reg.latency};
        proc_next = (proc_reg == '1) ? proc_reg : proc_reg + 32'd1;
        if (wk_reg.lat_valid)
        begin
            lat_next = lat_sum[64] ? '1 : lat_sum[63:0];
        end
        else
        begin
            lat_next = lat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
            proc_reg      <= '0;
            lat_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
            if (load_res)
            begin
                proc_reg <= proc_next;
                lat_reg  <= lat_next;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        wk_ready       = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = wk_reg.idx;
        mem_wdata      = ENT_W'(upd_reg);
        load_res       = 1'b0;
        res_valid_next = res_valid_reg && !out_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg[IDX_W-1:0];
                mem_wdata = ENT_W'(clr_ent);
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (IDX_W+1)'(NUM_SYMBOLS - 1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_READ:
            begin
                // Read data and product settle in this cycle.
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_WRITE;
                load_res   = 1'b0;
            end
            ST_WRITE:
            begin
                // Entered from clearing with nothing to write back, or from the update.
                if (clr_reg != (IDX_W+1)'(NUM_SYMBOLS))
                begin
                    wk_ready = !res_valid_reg || out_ready;
                    if (take)
                    begin
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    wk_ready = 1'b0;
                end
                if (clr_reg == (IDX_W+1)'(NUM_SYMBOLS))
                begin
                    clr_next = '0;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (state_reg == ST_UPDATE)
        begin
            state_next = ST_WRITE;
        end
        // Write back and present the result once the result register is free.
        if (state_reg == ST_WRITE && clr_reg == '0 && pend_reg
            && (!res_valid_reg || out_ready))
        begin
            mem_we         = 1'b1;
            load_res       = 1'b1;
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            pend_reg <= 1'b1;
        end
        else if (load_res)
        begin
            pend_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !wk_ready) else $error("item taken while clearing");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |-> (!res_valid_reg || out_ready)) else $error("result overwritten");
`endif

endmodule

// ===== hw/rtl/per_symbol_tick_statistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-symbol tick statistics
// Accumulates count, price-volume, volume, min, max, last bid and ask per symbol.
// ----------------------------------------------------------------------------
// Each tick passes through the table engine in order: read with the product
// formed alongside, update, then write back with the result loaded. The
// engine takes no new tick until it writes back the last one, so ticks queue
// in front of it. A result that is not taken holds the write back and the
// next tick. After reset all 256 table entries are cleared before the first
// tick is taken.
module per_symbol_tick_statistics (
    input  logic                clk,
    input  logic                rst_n,
    input  psts_pkg::tick_in_t  in_data,
    input  logic                in_valid,
    output logic                in_ready,
    output psts_pkg::tick_out_t out_data,
    output logic                out_valid,
    input  logic                out_ready
);
    import psts_pkg::*;

    work_t f_data, q_data;
    logic  f_valid, f_ready, q_valid, q_ready;

    psts_front u_front (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_valid(in_valid),
        .in_ready(in_ready), .wk_data(f_data), .wk_valid(f_valid), .wk_ready(f_ready)
    );

    psts_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(f_data), .wr_valid(f_valid),
        .wr_ready(f_ready), .rd_data(q_data), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    psts_back u_back (
        .clk(clk), .rst_n(rst_n), .wk_data(q_data), .wk_valid(q_valid),
        .wk_ready(q_ready), .out_data(out_data), .out_valid(out_valid),
        .out_ready(out_ready)
    );

endmodule
